FILE: hdl/sst_pkg.sv
// Shared types and constants for the scoped symbol stack table.
`timescale 1ns / 1ps

package sst_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned TOKEN_W  = 6;
  localparam int unsigned SCOPE_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 8;

  localparam logic [SCOPE_W-1:0] SCOPE_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT       = 3'd0,
    FN_LOOKUP       = 3'd1,
    FN_POP          = 3'd2,
    FN_REMOVE_NAME  = 3'd3,
    FN_REMOVE_SCOPE = 3'd4,
    FN_OPEN_SCOPE   = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_e;

  // One stored symbol as it moves between neighboring cells.
  typedef struct packed {
    logic [KEY_W-1:0]   name;
    logic [TOKEN_W-1:0] token;
    logic [SCOPE_W-1:0] scope;
  } entry_t;

  // Broadcast to every cell.
  typedef struct packed {
    logic               cmp;
    logic [KEY_W-1:0]   key;
    logic [TOKEN_W-1:0] token;
    logic [SCOPE_W-1:0] cmp_scope;
    logic [SCOPE_W-1:0] ins_scope;
  } cell_cmd_t;

  // Per-cell controls.
  typedef struct packed {
    logic occ;
    logic load;
    logic shift;
  } cell_ctl_t;

  // Registered compare results of one cell.
  typedef struct packed {
    logic hit;
    logic mis;
  } cell_flags_t;

endpackage

FILE: hdl/sst_if.sv
// Valid/ready channel interfaces for requests and results of the symbol table.
`timescale 1ns / 1ps

interface sst_in_if;
  logic                         valid;
  logic                         ready;
  logic [sst_pkg::FUNC_W-1:0]   func;
  logic [sst_pkg::KEY_W-1:0]    name_key;
  logic [sst_pkg::TOKEN_W-1:0]  token_kind;
  logic [sst_pkg::SCOPE_W-1:0]  scope_id;

  modport source (output valid, output func, output name_key, output token_kind,
                  output scope_id, input ready);
  modport sink (input valid, input func, input name_key, input token_kind,
                input scope_id, output ready);
endinterface

interface sst_out_if;
  logic                         valid;
  logic                         ready;
  logic [sst_pkg::STATUS_W-1:0] status;
  logic [sst_pkg::COUNT_W-1:0]  entry_count;
  logic [sst_pkg::SCOPE_W-1:0]  current_scope;

  modport source (output valid, output status, output entry_count, output current_scope,
                  input ready);
  modport sink (input valid, input status, input entry_count, input current_scope,
                output ready);
endinterface

FILE: hdl/sst_cell.sv
// One table slot: holds an entry, compares it, and loads or takes its upper neighbor.
`timescale 1ns / 1ps

module sst_cell #(
  parameter int unsigned TOKEN_BITS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sst_pkg::cell_cmd_t   cmd_i,
  input  sst_pkg::cell_ctl_t   ctl_i,
  input  sst_pkg::entry_t      nbr_i,
  output sst_pkg::entry_t      ent_o,
  output sst_pkg::cell_flags_t flags_o
);
  import sst_pkg::*;

  localparam int unsigned TOK_W = (TOKEN_BITS < TOKEN_W) ? TOKEN_BITS : TOKEN_W;

  logic [KEY_W-1:0]   name_q, name_d;
  logic [TOK_W-1:0]   tok_q, tok_d;
  logic [SCOPE_W-1:0] scope_q, scope_d;
  cell_flags_t        flags_q, flags_d;

  always_comb begin
    name_d  = name_q;
    tok_d   = tok_q;
    scope_d = scope_q;
    if (ctl_i.load) begin
      name_d  = cmd_i.key;
      tok_d   = cmd_i.token[TOK_W-1:0];
      scope_d = cmd_i.ins_scope;
    end else if (ctl_i.shift) begin
      name_d  = nbr_i.name;
      tok_d   = nbr_i.token[TOK_W-1:0];
      scope_d = nbr_i.scope;
    end
  end

  always_comb begin
    flags_d = flags_q;
    if (cmd_i.cmp) begin
      flags_d.hit = ctl_i.occ && (name_q == cmd_i.key);
      flags_d.mis = ctl_i.occ && (scope_q != cmd_i.cmp_scope);
    end
  end

  always_ff @(posedge clk_i) begin
    name_q  <= name_d;
    tok_q   <= tok_d;
    scope_q <= scope_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign ent_o.name  = name_q;
  assign ent_o.token = TOKEN_W'(tok_q);
  assign ent_o.scope = scope_q;
  assign flags_o     = flags_q;

endmodule

FILE: hdl/scoped_symbol_stack_table.sv
// Top level of the scoped symbol stack table: control, scan logic and the chain of cells.
//
//   Channel   Direction   Carries                                   Accepted when
//   req_i     in          func, name_key, token_kind, scope_id      valid && ready
//   rsp_o     out         status, entry_count, current_scope        valid && ready
//
// Each request item passes through a compare state, in which every cell compares its entry
// against the request, and an update state, in which the registered compare flags are scanned
// and the table, count and scope are updated. A new item can be taken in the update state
// once the result register is free, so the block need not return to idle between items.
// Reset clears the entry count and the current scope; cell storage is not cleared
// and needs no clearing pass, since only slots below the count are ever examined.
// The result sits in an output register. If it is still not taken when the next
// result is ready, the block holds in its update cycle and takes no new item.
`timescale 1ns / 1ps

module scoped_symbol_stack_table #(
  parameter int unsigned TABLE_DEPTH = 128,
  parameter int unsigned TOKEN_BITS  = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sst_in_if.sink           req_i,
  sst_out_if.source        rsp_o
);
  import sst_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned STEPS = $clog2(TABLE_DEPTH);

  // Request held for the duration of its work.
  func_e              func_q;
  logic [KEY_W-1:0]   key_q;
  logic [TOKEN_W-1:0] token_q;
  logic [SCOPE_W-1:0] scope_in_q;

  // Architectural state.
  logic [CNT_W-1:0]   count_q, count_d;
  logic [SCOPE_W-1:0] scope_now_q, scope_now_d;

  // Control state and the result register.
  state_e             state_q, state_d;
  logic               out_valid_q;
  status_e            status_q, status_d;
  logic [CNT_W-1:0]   out_count_q;
  logic [SCOPE_W-1:0] out_scope_q;

  logic in_fire;
  logic out_free;
  logic apply_fire;
  logic cmp_en;
  logic in_ready;

  // Chain signals.
  cell_cmd_t               cmd;
  cell_ctl_t               ctl   [TABLE_DEPTH];
  entry_t                  ents  [TABLE_DEPTH];
  entry_t                  nbrs  [TABLE_DEPTH];
  cell_flags_t             flags [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  hit_vec;
  logic [TABLE_DEPTH-1:0]  mis_vec;
  logic [TABLE_DEPTH-1:0]  hit_sfx;
  logic [TABLE_DEPTH-1:0]  keep_vec;
  logic [TABLE_DEPTH-1:0]  scope_edge;
  logic [TABLE_DEPTH-1:0]  load_vec;
  logic [TABLE_DEPTH-1:0]  shift_vec;
  logic [CNT_W-1:0]        scope_cnt;
  logic                    any_hit;
  logic                    do_load;
  logic                    do_shift;

  // --------------------------------------------------------------------------
  // Handshake and sequencing.
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_q || rsp_o.ready;
  assign in_fire  = req_i.valid && in_ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) state_d = in_fire ? S_CMP : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmp_en     = 1'b0;
    apply_fire = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_CMP: begin
        cmp_en = 1'b1;
      end
      S_APPLY: begin
        apply_fire = out_free;
        in_ready   = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign req_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q     <= func_e'(req_i.func);
      key_q      <= req_i.name_key;
      token_q    <= req_i.token_kind;
      scope_in_q <= req_i.scope_id;
    end
  end

  // --------------------------------------------------------------------------
  // Chain of cells. Each slot compares in the compare cycle; in the update
  // cycle it may load the new entry or take the entry of the slot above it.
  // --------------------------------------------------------------------------
  assign cmd.cmp       = cmp_en;
  assign cmd.key       = key_q;
  assign cmd.token     = token_q;
  assign cmd.cmp_scope = scope_in_q;
  assign cmd.ins_scope = scope_now_q;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i < TABLE_DEPTH - 1) begin : g_mid
      assign nbrs[i] = ents[i+1];
    end else begin : g_top
      assign nbrs[i] = ents[i];
    end

    assign ctl[i].occ   = count_q > CNT_W'(i);
    assign ctl[i].load  = load_vec[i];
    assign ctl[i].shift = shift_vec[i];
    assign hit_vec[i]   = flags[i].hit;
    assign mis_vec[i]   = flags[i].mis;

    sst_cell #(
      .TOKEN_BITS (TOKEN_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .ctl_i   (ctl[i]),
      .nbr_i   (nbrs[i]),
      .ent_o   (ents[i]),
      .flags_o (flags[i])
    );
  end

  // --------------------------------------------------------------------------
  // Scan of the registered flags. Suffix ORs are built in ceil(log2(depth)) steps:
  // bit i of a suffix OR is set when any flag at slot i or above is set.
  // --------------------------------------------------------------------------
  always_comb begin
    hit_sfx  = hit_vec;
    keep_vec = mis_vec;
    for (int s = 0; s < STEPS; s++) begin
      hit_sfx  = hit_sfx | (hit_sfx >> (1 << s));
      keep_vec = keep_vec | (keep_vec >> (1 << s));
    end
  end

  assign any_hit = hit_sfx[0];

  // The newest slot whose scope differs from the given one marks the new top;
  // everything above it is popped by a scope removal.
  assign scope_edge = keep_vec & ~(keep_vec >> 1);

  always_comb begin
    scope_cnt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (scope_edge[i]) scope_cnt = scope_cnt | CNT_W'(i + 1);
    end
  end

  // A slot loads on insert only at the first free slot; a name removal shifts every
  // slot at or above the newest match down by one.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_move
    assign load_vec[i] = do_load && (count_q == CNT_W'(i));
    if (i < TABLE_DEPTH - 1) begin : g_mid
      assign shift_vec[i] = do_shift && !hit_sfx[i+1];
    end else begin : g_top
      assign shift_vec[i] = do_shift;
    end
  end

  // --------------------------------------------------------------------------
  // Update of count, scope and status.
  // --------------------------------------------------------------------------
  always_comb begin
    count_d     = count_q;
    scope_now_d = scope_now_q;
    status_d    = ST_OK;
    do_load     = 1'b0;
    do_shift    = 1'b0;
    case (func_q)
      FN_INSERT: begin
        if (count_q == CNT_W'(TABLE_DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          do_load = apply_fire;
          count_d = count_q + CNT_W'(1);
        end
      end
      FN_LOOKUP: begin
        status_d = any_hit ? ST_OK : ST_MISS;
      end
      FN_POP: begin
        if (count_q == '0) begin
          status_d = ST_MISS;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      FN_REMOVE_NAME: begin
        if (any_hit) begin
          do_shift = apply_fire;
          count_d  = count_q - CNT_W'(1);
        end else begin
          status_d = ST_MISS;
        end
      end
      FN_REMOVE_SCOPE: begin
        count_d = scope_cnt;
        if ((scope_now_q == scope_in_q) && (scope_now_q != '0)) begin
          scope_now_d = scope_now_q - SCOPE_W'(1);
        end
      end
      FN_OPEN_SCOPE: begin
        if (scope_now_q == SCOPE_MAX) begin
          status_d = ST_FULL;
        end else begin
          scope_now_d = scope_now_q + SCOPE_W'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scope_now_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (apply_fire) begin
        count_q     <= count_d;
        scope_now_q <= scope_now_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_fire) begin
      status_q    <= status_d;
      out_count_q <= count_d;
      out_scope_q <= scope_now_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.entry_count   = COUNT_W'(out_count_q);
  assign rsp_o.current_scope = out_scope_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_cmp_to_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |=> state_q == S_APPLY)
    else $error("compare cycle not followed by update cycle");

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(load_vec))
    else $error("more than one slot loads on insert");

  a_one_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(scope_edge))
    else $error("scope scan found more than one top");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_APPLY)
    else $error("result appeared outside the update cycle");

endmodule
